FILE: rtl/lep_pkg.sv
// Shared types, constants and register codes of the line edge peak locator.
package lep_pkg;

    // Default build values
    localparam int LINE_LENGTH_DEF = 128;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths
    localparam int PIXEL_W    = 12;
    localparam int S_TDATA_W  = 16;
    localparam int POS_W      = 7;
    localparam int DISP_W     = 8;
    localparam int M_TDATA_W  = 16;
    localparam int TAP_W      = 4;
    localparam int MARGIN_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Register reset values
    localparam logic [TAP_W-1:0]    TAP_CURRENT_RST  = 4'h1;
    localparam logic [TAP_W-1:0]    TAP_ONE_BACK_RST = 4'h0;
    localparam logic [TAP_W-1:0]    TAP_TWO_BACK_RST = 4'hF;
    localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RST  = 6'd4;

    // Register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_CURRENT  = 2'd0,
        CFG_TAP_ONE_BACK = 2'd1,
        CFG_TAP_TWO_BACK = 2'd2,
        CFG_EDGE_MARGIN  = 2'd3
    } cfg_reg_t;

    // Live configuration
    typedef struct packed {
        logic signed [TAP_W-1:0] tap_current;
        logic signed [TAP_W-1:0] tap_one_back;
        logic signed [TAP_W-1:0] tap_two_back;
        logic [MARGIN_W-1:0]     edge_margin;
    } lep_cfg_t;

    // Side info traveling with each filter response
    typedef struct packed {
        logic             last;
        logic             in_window;
        logic [POS_W-1:0] pos;
    } lep_tag_t;

endpackage

FILE: rtl/lep_fir.sv
// Input register, delay line, pixel counter and 3-tap FIR with response register.
module lep_fir
    import lep_pkg::*;
#(
    parameter int LINE_LENGTH = LINE_LENGTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lep_cfg_t                      cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [PIXEL_W-1:0]            pixel,
    input  logic                          s_tlast,
    output logic                          resp_valid,
    output logic signed [SAMPLE_BITS+5:0] resp,
    output lep_tag_t                      resp_tag,
    input  logic                          resp_take
);

    localparam int RESP_W = SAMPLE_BITS + 6;
    localparam int CNT_W  = $clog2(LINE_LENGTH + 1);
    localparam int SUM_W  = ((CNT_W > MARGIN_W) ? CNT_W : MARGIN_W) + 1;

    // Input stage
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] x_reg;
    logic                   last_reg;

    // Line state
    logic [SAMPLE_BITS-1:0] dl0_reg, dl1_reg;
    logic [CNT_W-1:0]       cnt_reg;

    // Response stage
    logic                     resp_valid_reg;
    logic signed [RESP_W-1:0] resp_reg;
    lep_tag_t                 tag_reg;

    logic resp_free, in_move, in_accept;
    logic signed [TAP_W-1:0]     tc, t1, t2;
    logic signed [SAMPLE_BITS:0] xs, d0s, d1s;
    logic signed [RESP_W-1:0]    p0, p1, p2, sum_next;
    logic [SUM_W-1:0]            idx_ext, margin_ext, far_end;
    logic                        in_window_next;

    // Stage hand-off
    assign resp_free = !resp_valid_reg || resp_take;
    assign in_move   = in_valid_reg && resp_free;
    assign s_tready  = !in_valid_reg || in_move;
    assign in_accept = s_tvalid && s_tready;

    // Filter products, samples taken as non-negative
    assign tc  = cfg.tap_current;
    assign t1  = cfg.tap_one_back;
    assign t2  = cfg.tap_two_back;
    assign xs  = $signed({1'b0, x_reg});
    assign d0s = $signed({1'b0, dl0_reg});
    assign d1s = $signed({1'b0, dl1_reg});
    assign p0  = RESP_W'(tc) * RESP_W'(xs);
    assign p1  = RESP_W'(t1) * RESP_W'(d0s);
    assign p2  = RESP_W'(t2) * RESP_W'(d1s);
    assign sum_next = p0 + p1 + p2;

    // Search window: margin <= idx < LINE_LENGTH - margin
    assign idx_ext    = SUM_W'(cnt_reg);
    assign margin_ext = SUM_W'(cfg.edge_margin);
    assign far_end    = idx_ext + margin_ext;
    assign in_window_next = (idx_ext >= margin_ext) && (far_end < SUM_W'(LINE_LENGTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            resp_valid_reg <= 1'b0;
            dl0_reg        <= '0;
            dl1_reg        <= '0;
            cnt_reg        <= '0;
        end else begin
            // input register
            if (in_accept) begin
                in_valid_reg <= 1'b1;
                x_reg        <= SAMPLE_BITS'(pixel);
                last_reg     <= s_tlast;
            end else if (in_move) begin
                in_valid_reg <= 1'b0;
            end

            // filter step and line bookkeeping
            if (in_move) begin
                resp_valid_reg    <= 1'b1;
                resp_reg          <= sum_next;
                tag_reg.last      <= last_reg;
                tag_reg.in_window <= in_window_next;
                tag_reg.pos       <= POS_W'(cnt_reg);
                if (last_reg) begin
                    dl0_reg <= '0;
                    dl1_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    dl0_reg <= x_reg;
                    dl1_reg <= dl0_reg;
                    if (cnt_reg < CNT_W'(LINE_LENGTH)) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
            end else if (resp_take) begin
                resp_valid_reg <= 1'b0;
            end
        end
    end

    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;
    assign resp_tag   = tag_reg;

endmodule

FILE: rtl/lep_peak.sv
// Peak tracker, position slots and result register.
module lep_peak
    import lep_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          resp_valid,
    input  logic signed [SAMPLE_BITS+5:0] resp,
    input  lep_tag_t                      resp_tag,
    output logic                          resp_take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [M_TDATA_W-1:0]          m_tdata,
    output logic                          m_tuser
);

    localparam int RESP_W = SAMPLE_BITS + 6;

    // Search state
    logic signed [RESP_W-1:0] best_reg;
    logic [POS_W-1:0]         best_pos_reg;
    logic                     found_reg;

    // Slots
    logic             slot_reg;
    logic [POS_W-1:0] prev_reg, pres_reg;

    // Result register
    logic              out_valid_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_found_reg;
    logic              out_slot_reg;
    logic [DISP_W-1:0] out_disp_reg;

    logic             out_free, hit;
    logic             found_next;
    logic [POS_W-1:0] best_pos_next, prev_next, pres_next;

    // A line-end word waits only for room in the result register
    assign out_free  = !out_valid_reg || m_tready;
    assign resp_take = resp_valid && (!resp_tag.last || out_free);

    // First strictly greater response inside the window
    assign hit           = resp_tag.in_window && (resp > best_reg);
    assign found_next    = found_reg || hit;
    assign best_pos_next = hit ? resp_tag.pos : best_pos_reg;

    // Slot update at line end, kept when nothing was found
    assign prev_next = (found_next && !slot_reg) ? best_pos_next : prev_reg;
    assign pres_next = (found_next && slot_reg)  ? best_pos_next : pres_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg      <= '0;
            best_pos_reg  <= '0;
            found_reg     <= 1'b0;
            slot_reg      <= 1'b0;
            prev_reg      <= '0;
            pres_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (resp_take && resp_tag.last) begin
                // close the line
                prev_reg      <= prev_next;
                pres_reg      <= pres_next;
                slot_reg      <= !slot_reg;
                best_reg      <= '0;
                best_pos_reg  <= '0;
                found_reg     <= 1'b0;
                out_valid_reg <= 1'b1;
                out_pos_reg   <= slot_reg ? pres_next : prev_next;
                out_found_reg <= found_next;
                out_slot_reg  <= slot_reg;
                out_disp_reg  <= DISP_W'({1'b0, pres_next}) - DISP_W'({1'b0, prev_next});
            end else begin
                if (resp_take && hit) begin
                    best_reg     <= resp;
                    best_pos_reg <= resp_tag.pos;
                    found_reg    <= 1'b1;
                end
                if (m_tready) begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_disp_reg, out_found_reg, out_pos_reg};
    assign m_tuser  = out_slot_reg;

endmodule

FILE: rtl/line_edge_peak_locator_top.sv
// Top level of the line edge peak locator: config registers and the two pipeline parts.
// Result path: the result word of a line reaches m_tvalid after its line-end pixel is
//   accepted, through the input register, FIR response register and result register.
// Throughput: one pixel per cycle; input stalls only while a line-end word waits
//   for a result register that m_tready has not yet emptied.
// Reset: synchronous, active-low aresetn restores the register defaults, clears
//   the delay line, counter, peak search and both slots, and empties all stages.
module line_edge_peak_locator_top
    import lep_pkg::*;
#(
    parameter int LINE_LENGTH = LINE_LENGTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // pixel stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] pixel_value, [15:12] zero
    input  logic                  s_tlast,   // line_end
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [6:0] peak_position, [7] peak_found,
                                             // [15:8] displacement
    output logic                  m_tuser,   // slot_written
    // config writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lep_cfg_t cfg_reg;

    logic                          resp_valid, resp_take;
    logic signed [SAMPLE_BITS+5:0] resp;
    lep_tag_t                      resp_tag;

    // Config registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tap_current  <= TAP_CURRENT_RST;
            cfg_reg.tap_one_back <= TAP_ONE_BACK_RST;
            cfg_reg.tap_two_back <= TAP_TWO_BACK_RST;
            cfg_reg.edge_margin  <= EDGE_MARGIN_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_TAP_CURRENT:  cfg_reg.tap_current  <= cfg_data[TAP_W-1:0];
                CFG_TAP_ONE_BACK: cfg_reg.tap_one_back <= cfg_data[TAP_W-1:0];
                CFG_TAP_TWO_BACK: cfg_reg.tap_two_back <= cfg_data[TAP_W-1:0];
                CFG_EDGE_MARGIN:  cfg_reg.edge_margin  <= cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    lep_fir #(
        .LINE_LENGTH(LINE_LENGTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_fir (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .pixel     (s_tdata[PIXEL_W-1:0]),
        .s_tlast   (s_tlast),
        .resp_valid(resp_valid),
        .resp      (resp),
        .resp_tag  (resp_tag),
        .resp_take (resp_take)
    );

    lep_peak #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_peak (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .resp_valid(resp_valid),
        .resp      (resp),
        .resp_tag  (resp_tag),
        .resp_take (resp_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: rtl/lep_checker.sv
// Port-level checks of the line edge peak locator, bound to the top level.
module lep_checker
    import lep_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    logic             exp_slot_reg;
    logic [POS_W-1:0] prev_seen_reg, pres_seen_reg;
    logic [2:0]       open_lines_reg;
    logic             line_in, line_out;
    logic [POS_W-1:0] pos;
    logic             found;
    logic [DISP_W-1:0] disp;

    assign pos      = m_tdata[POS_W-1:0];
    assign found    = m_tdata[POS_W];
    assign disp     = m_tdata[M_TDATA_W-1:POS_W+1];
    assign line_in  = s_tvalid && s_tready && s_tlast;
    assign line_out = m_tvalid && m_tready;

    // Shadow of the slots and of lines not yet answered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_slot_reg   <= 1'b0;
            prev_seen_reg  <= '0;
            pres_seen_reg  <= '0;
            open_lines_reg <= '0;
        end else begin
            if (line_out) begin
                exp_slot_reg <= !exp_slot_reg;
                if (m_tuser) begin
                    pres_seen_reg <= pos;
                end else begin
                    prev_seen_reg <= pos;
                end
            end
            open_lines_reg <= open_lines_reg + 3'(line_in) - 3'(line_out);
        end
    end

    // A stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Slots alternate, starting with the previous slot
    a_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == exp_slot_reg)
        else $error("slot order broken");

    // No peak found keeps the slot value
    a_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !found |->
            pos == (m_tuser ? pres_seen_reg : prev_seen_reg))
        else $error("slot changed without a peak");

    // Displacement is present minus previous
    a_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> disp == (m_tuser ? (DISP_W'(pos) - DISP_W'(prev_seen_reg))
                                      : (DISP_W'(pres_seen_reg) - DISP_W'(pos))))
        else $error("displacement mismatch");

    // Every result belongs to an accepted line end
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> open_lines_reg != 3'd0)
        else $error("result without a line end");

endmodule

bind line_edge_peak_locator_top lep_checker u_lep_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
